>>> rtl/ekmc_pkg.sv
// Package: shared types, register indexes and constants of the knob menu controller.
package ekmc_pkg;

  localparam logic [2:0]  PAGE_FIRST  = 3'd1;
  localparam logic [2:0]  PAGE_THREE  = 3'd3;
  localparam logic [2:0]  PAGE_LAST   = 3'd5;

  localparam logic [1:0]  STAGE_BROWSE = 2'd0;
  localparam logic [1:0]  STAGE_SELECT = 2'd1;
  localparam logic [1:0]  STAGE_ADJUST = 2'd2;
  localparam logic [1:0]  STAGE_APPLY  = 2'd3;

  localparam logic [7:0]  HISTORY_FULL = 8'hFF;
  localparam logic [10:0] HOLD_MAX     = 11'd2047;

  localparam logic [15:0] PULSE_PERIOD_RST = 16'd1000;
  localparam logic [10:0] HOLD_TICKS_RST   = 11'd100;
  localparam logic [9:0]  PUMP_LIMIT_RST   = 10'd300;
  localparam logic [7:0]  LOOP_LIMIT_RST   = 8'd50;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PULSE_PERIOD = 3'd0,
    REG_HOLD_TICKS   = 3'd1,
    REG_PUMP_LIMIT   = 3'd2,
    REG_LOOP_LIMIT   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] pulse_period;
    logic [10:0] hold_ticks;
    logic [9:0]  pump_limit;
    logic [7:0]  loop_limit;
  } cfg_t;

  typedef struct packed {
    logic knob_a;
    logic knob_b;
    logic button_level;
    logic a_rose;
    logic button_rose;
    logic pulse_done;
    logic stage_done;
  } tick_t;

  typedef struct packed {
    logic [2:0]        page_now;
    logic [1:0]        stage_now;
    logic              pump_line_selected;
    logic [9:0]        pump_value_out;
    logic signed [7:0] power_value;
    logic [7:0]        loops;
    logic              pulse_on;
    logic              dc_on;
    logic              pulse_ready;
  } result_t;

endpackage

>>> rtl/ekmc_if.sv
// Interfaces: tick input channel and status result channel.
interface ekmc_tick_if;
  logic valid;
  logic ready;
  logic knob_a;
  logic knob_b;
  logic button_level;
  logic a_rose;
  logic button_rose;
  logic pulse_done;
  logic stage_done;

  modport source (output valid, knob_a, knob_b, button_level, a_rose, button_rose,
                  pulse_done, stage_done, input ready);
  modport sink (input valid, knob_a, knob_b, button_level, a_rose, button_rose,
                pulse_done, stage_done, output ready);
endinterface

interface ekmc_status_if;
  logic              valid;
  logic              ready;
  logic [2:0]        page_now;
  logic [1:0]        stage_now;
  logic              pump_line_selected;
  logic [9:0]        pump_value_out;
  logic signed [7:0] power_value;
  logic [7:0]        loops;
  logic              pulse_on;
  logic              dc_on;
  logic              pulse_ready;

  modport source (output valid, page_now, stage_now, pump_line_selected, pump_value_out,
                  power_value, loops, pulse_on, dc_on, pulse_ready, input ready);
  modport sink (input valid, page_now, stage_now, pump_line_selected, pump_value_out,
                power_value, loops, pulse_on, dc_on, pulse_ready, output ready);
endinterface

>>> rtl/ekmc_cfg.sv
// Configuration register file with plain write port.
module ekmc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wen,
  input  logic [ekmc_pkg::CFG_INDEX_W-1:0] index,
  input  logic [ekmc_pkg::CFG_DATA_W-1:0]  data,
  output ekmc_pkg::cfg_t                 cfg
);
  import ekmc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_period <= PULSE_PERIOD_RST;
      cfg.hold_ticks   <= HOLD_TICKS_RST;
      cfg.pump_limit   <= PUMP_LIMIT_RST;
      cfg.loop_limit   <= LOOP_LIMIT_RST;
    end else if (wen) begin
      case (cfg_reg_t'(index))
        REG_PULSE_PERIOD: cfg.pulse_period <= data[15:0];
        REG_HOLD_TICKS:   cfg.hold_ticks   <= data[10:0];
        REG_PUMP_LIMIT:   cfg.pump_limit   <= data[9:0];
        REG_LOOP_LIMIT:   cfg.loop_limit   <= data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ekmc_core.sv
// Menu state registers and the single-pass tick update.
module ekmc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ekmc_pkg::tick_t   tick,
  input  ekmc_pkg::cfg_t    cfg,
  output ekmc_pkg::result_t result
);
  import ekmc_pkg::*;

  logic [15:0]       pulse_count, pulse_count_next;
  logic [7:0]        a_history, a_history_next;
  logic              rotate_pending, rotate_pending_next;
  logic              press_pending, press_pending_next;
  logic [2:0]        page_reg, page_reg_next;
  logic [1:0]        edit_stage, edit_stage_next;
  logic              pump_line, pump_line_next;
  logic [9:0]        pump_setting, pump_setting_next;
  logic signed [7:0] power_setting, power_setting_next;
  logic [7:0]        loop_count, loop_count_next;
  logic              pulse_mode, pulse_mode_next;
  logic              dc_hold, dc_hold_next;
  logic [10:0]       hold_count, hold_count_next;

  logic              rot_p;
  logic              press_p;
  logic [15:0]       pc_base;
  logic [16:0]       pc_inc;
  logic              fire;
  logic              fwd;
  logic signed [11:0] pump_t;
  logic signed [8:0]  pow_t;
  logic signed [9:0]  loop_t;
  logic              in_menu;
  logic              on_last;

  always_comb begin
    rot_p   = rotate_pending | tick.a_rose;
    press_p = press_pending | tick.button_rose;
    edit_stage_next = tick.stage_done ? STAGE_BROWSE : edit_stage;

    pc_base = tick.pulse_done ? 16'd0 : pulse_count;
    pc_inc  = {1'b0, pc_base} + 17'd1;
    pulse_count_next = (pc_inc >= {1'b0, cfg.pulse_period}) ? cfg.pulse_period
                                                             : pc_inc[15:0];

    a_history_next = {a_history[6:0], tick.knob_a};
    fire = rot_p && (a_history_next == HISTORY_FULL);
    fwd  = tick.knob_a ^ tick.knob_b;
    rotate_pending_next = fire ? 1'b0 : rot_p;

    page_reg_next  = page_reg;
    pump_line_next = pump_line;
    pump_t = $signed({2'b00, pump_setting});
    pow_t  = {power_setting[7], power_setting};
    loop_t = $signed({2'b00, loop_count});
    power_setting_next = power_setting;

    if (fire) begin
      case (edit_stage_next)
        STAGE_BROWSE: begin
          if (fwd) page_reg_next = (page_reg >= PAGE_LAST) ? PAGE_FIRST : page_reg + 3'd1;
          else     page_reg_next = (page_reg <= PAGE_FIRST) ? PAGE_LAST : page_reg - 3'd1;
        end
        STAGE_SELECT: pump_line_next = ~pump_line;
        STAGE_ADJUST: begin
          if (pump_line) begin
            pump_t = fwd ? pump_t + 12'sd1 : pump_t - 12'sd1;
          end else begin
            pow_t = fwd ? pow_t - 9'sd1 : pow_t + 9'sd1;
            if (pow_t > 9'sd127)       power_setting_next = 8'sd127;
            else if (pow_t < -9'sd128) power_setting_next = -8'sd128;
            else                       power_setting_next = pow_t[7:0];
          end
        end
        default: loop_t = fwd ? loop_t + 10'sd1 : loop_t - 10'sd1;
      endcase
    end

    if (pump_t > $signed({2'b00, cfg.pump_limit})) pump_setting_next = cfg.pump_limit;
    else if (pump_t < 12'sd0)                      pump_setting_next = 10'd0;
    else                                           pump_setting_next = pump_t[9:0];

    if (loop_t > $signed({2'b00, cfg.loop_limit})) loop_t = $signed({2'b00, cfg.loop_limit});
    loop_count_next = (loop_t < 10'sd1) ? 8'd1 : loop_t[7:0];

    in_menu = (page_reg_next == PAGE_FIRST) || (page_reg_next == PAGE_THREE);
    on_last = (page_reg_next == PAGE_LAST);

    pulse_mode_next = pulse_mode;
    dc_hold_next    = dc_hold;
    if (tick.button_level && press_p && (in_menu || on_last)) begin
      hold_count_next    = (hold_count < HOLD_MAX) ? hold_count + 11'd1 : hold_count;
      press_pending_next = press_p;
    end else begin
      hold_count_next    = 11'd0;
      press_pending_next = 1'b0;
    end

    if (hold_count_next > cfg.hold_ticks) begin
      if (in_menu) begin
        if (edit_stage_next < STAGE_APPLY) edit_stage_next = edit_stage_next + 2'd1;
      end else if (on_last) begin
        if (!dc_hold) begin
          pulse_mode_next = ~pulse_mode;
          dc_hold_next    = 1'b1;
          edit_stage_next = STAGE_BROWSE;
        end else begin
          dc_hold_next = 1'b0;
          if (pulse_mode) edit_stage_next = STAGE_APPLY;
        end
      end
      hold_count_next    = 11'd0;
      press_pending_next = 1'b0;
    end

    result.page_now           = page_reg_next;
    result.stage_now          = edit_stage_next;
    result.pump_line_selected = pump_line_next;
    result.pump_value_out     = pump_setting_next;
    result.power_value        = power_setting_next;
    result.loops              = loop_count_next;
    result.pulse_on           = pulse_mode_next;
    result.dc_on              = dc_hold_next;
    result.pulse_ready        = (pulse_count_next >= cfg.pulse_period);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count    <= 16'd0;
      a_history      <= HISTORY_FULL;
      rotate_pending <= 1'b0;
      press_pending  <= 1'b0;
      page_reg       <= PAGE_FIRST;
      edit_stage     <= STAGE_BROWSE;
      pump_line      <= 1'b1;
      pump_setting   <= 10'd0;
      power_setting  <= 8'sd0;
      loop_count     <= 8'd1;
      pulse_mode     <= 1'b0;
      dc_hold        <= 1'b0;
      hold_count     <= 11'd0;
    end else if (en) begin
      pulse_count    <= pulse_count_next;
      a_history      <= a_history_next;
      rotate_pending <= rotate_pending_next;
      press_pending  <= press_pending_next;
      page_reg       <= page_reg_next;
      edit_stage     <= edit_stage_next;
      pump_line      <= pump_line_next;
      pump_setting   <= pump_setting_next;
      power_setting  <= power_setting_next;
      loop_count     <= loop_count_next;
      pulse_mode     <= pulse_mode_next;
      dc_hold        <= dc_hold_next;
      hold_count     <= hold_count_next;
    end
  end

endmodule

>>> rtl/encoder_knob_menu_controller_top.sv
// Top level: knob menu controller with input and result registers.
//
//   channel   dir  width  content
//   tick      in   7      knob pins, button, edge flags, software acks
//   status    out  35     page, stage, line, pump, power, loops, modes, ready
//   cfg       in   3+16   register index and write data, write enable
//
// One tick beat per cycle sustained while the status side is ready; a beat's result reaches
// the status port after acceptance through the input register, then the result register.
// The result register decouples the sides: a new tick is taken while a result waits
// if the input register is empty, and the input register holds when both are full.
// rst is synchronous and restores all menu state and register defaults.
module encoder_knob_menu_controller_top (
  input  logic                             clk,
  input  logic                             rst,
  ekmc_tick_if.sink                        tick,
  ekmc_status_if.source                    status,
  input  logic                             cfg_wen,
  input  logic [ekmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ekmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ekmc_pkg::*;

  cfg_t    cfg;
  tick_t   in_q;
  logic    in_valid;
  result_t core_res;
  result_t out_q;
  logic    out_valid;
  logic    advance;

  ekmc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wen   (cfg_wen),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  ekmc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .tick   (in_q),
    .cfg    (cfg),
    .result (core_res)
  );

  assign advance    = in_valid && (!out_valid || status.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tick.valid && tick.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_q.knob_a       <= tick.knob_a;
      in_q.knob_b       <= tick.knob_b;
      in_q.button_level <= tick.button_level;
      in_q.a_rose       <= tick.a_rose;
      in_q.button_rose  <= tick.button_rose;
      in_q.pulse_done   <= tick.pulse_done;
      in_q.stage_done   <= tick.stage_done;
    end
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign status.valid              = out_valid;
  assign status.page_now           = out_q.page_now;
  assign status.stage_now          = out_q.stage_now;
  assign status.pump_line_selected = out_q.pump_line_selected;
  assign status.pump_value_out     = out_q.pump_value_out;
  assign status.power_value        = out_q.power_value;
  assign status.loops              = out_q.loops;
  assign status.pulse_on           = out_q.pulse_on;
  assign status.dc_on              = out_q.dc_on;
  assign status.pulse_ready        = out_q.pulse_ready;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the knob menu controller: directed menu walks, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ekmc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd4;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_TICKS  = 1200;
  localparam int POWER_MAX     = 127;
  localparam int POWER_MIN     = -128;
  localparam int TIMEOUT_NS    = 20_000_000;

  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ekmc_tick_if   tick_ch ();
  ekmc_status_if status_ch ();

  encoder_knob_menu_controller_top uut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .status    (status_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  cfg_t        menu_cfg;
  int unsigned pulse_cnt;
  logic [7:0]  a_hist;
  bit          turn_pend;
  bit          press_pend;
  logic [2:0]  page;
  logic [1:0]  stage;
  bit          pump_sel;
  int          pump;
  int          power;
  int          loops_set;
  bit          pulse_mode;
  bit          dc_hold;
  int unsigned hold_cnt;

  result_t  status_q[$];
  int       errors;
  int       n_ticks;
  int       n_results;
  int       n_turns;
  int       n_presses;
  int       n_writes;
  int       burst_left;
  int       gap_max;
  rx_mode_t rx_mode;
  int       rx_left;
  int       rx_phase;

  function automatic void reset_menu_model();
    menu_cfg.pulse_period = PULSE_PERIOD_RST;
    menu_cfg.hold_ticks   = HOLD_TICKS_RST;
    menu_cfg.pump_limit   = PUMP_LIMIT_RST;
    menu_cfg.loop_limit   = LOOP_LIMIT_RST;
    pulse_cnt  = 0;
    a_hist     = HISTORY_FULL;
    turn_pend  = 1'b0;
    press_pend = 1'b0;
    page       = PAGE_FIRST;
    stage      = STAGE_BROWSE;
    pump_sel   = 1'b1;
    pump       = 0;
    power      = 0;
    loops_set  = 1;
    pulse_mode = 1'b0;
    dc_hold    = 1'b0;
    hold_cnt   = 0;
  endfunction

  function automatic void turn_knob(input bit fwd);
    n_turns++;
    case (stage)
      STAGE_BROWSE: begin
        if (fwd) page = (page >= PAGE_LAST) ? PAGE_FIRST : page + 3'd1;
        else page = (page <= PAGE_FIRST) ? PAGE_LAST : page - 3'd1;
      end
      STAGE_SELECT: begin
        pump_sel = !pump_sel;
      end
      STAGE_ADJUST: begin
        if (pump_sel) begin
          pump = pump + (fwd ? 1 : -1);
        end else begin
          power = power + (fwd ? -1 : 1);
          if (power > POWER_MAX) power = POWER_MAX;
          if (power < POWER_MIN) power = POWER_MIN;
        end
      end
      default: begin
        loops_set = loops_set + (fwd ? 1 : -1);
      end
    endcase
  endfunction

  function automatic void advance_menu(input tick_t t, output result_t r);
    bit menu_page;
    if (t.a_rose) turn_pend = 1'b1;
    if (t.button_rose) press_pend = 1'b1;
    if (t.stage_done) stage = STAGE_BROWSE;
    if (t.pulse_done) pulse_cnt = 0;
    pulse_cnt++;
    if (pulse_cnt >= menu_cfg.pulse_period) pulse_cnt = menu_cfg.pulse_period;
    a_hist = {a_hist[6:0], t.knob_a};
    if (turn_pend && a_hist == HISTORY_FULL) begin
      turn_knob(t.knob_a != t.knob_b);
      turn_pend = 1'b0;
    end
    if (pump > int'(menu_cfg.pump_limit)) pump = menu_cfg.pump_limit;
    if (pump < 0) pump = 0;
    if (loops_set > int'(menu_cfg.loop_limit)) loops_set = menu_cfg.loop_limit;
    if (loops_set < 1) loops_set = 1;
    menu_page = (page == PAGE_FIRST) || (page == PAGE_THREE);
    if (t.button_level && press_pend && (menu_page || page == PAGE_LAST)) begin
      if (hold_cnt < HOLD_MAX) hold_cnt++;
    end else begin
      hold_cnt   = 0;
      press_pend = 1'b0;
    end
    if (hold_cnt > menu_cfg.hold_ticks) begin
      n_presses++;
      if (menu_page) begin
        if (stage != STAGE_APPLY) stage++;
      end else if (page == PAGE_LAST) begin
        if (!dc_hold) begin
          pulse_mode = !pulse_mode;
          dc_hold    = 1'b1;
          stage      = STAGE_BROWSE;
        end else begin
          dc_hold = 1'b0;
          if (pulse_mode) stage = STAGE_APPLY;
        end
      end
      hold_cnt   = 0;
      press_pend = 1'b0;
    end
    r.page_now           = page;
    r.stage_now          = stage;
    r.pump_line_selected = pump_sel;
    r.pump_value_out     = pump[9:0];
    r.power_value        = power[7:0];
    r.loops              = loops_set[7:0];
    r.pulse_on           = pulse_mode;
    r.dc_on              = dc_hold;
    r.pulse_ready        = (pulse_cnt >= menu_cfg.pulse_period);
  endfunction

  function automatic string fmt_status(input result_t r);
    return $sformatf("page=%0d stage=%0d line=%0d pump=%0d power=%0d loops=%0d pulse=%0d dc=%0d rdy=%0d",
                     r.page_now, r.stage_now, r.pump_line_selected, r.pump_value_out,
                     r.power_value, r.loops, r.pulse_on, r.dc_on, r.pulse_ready);
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic bit next_ready();
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3, 0));
      rx_left = $urandom_range(200, 40);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:  return 1'b1;
      RX_COIN:  return $urandom_range(1, 0);
      RX_COMB:  return (rx_phase % 4) != 0;
      default:  return (rx_phase % 12) >= 8;
    endcase
  endfunction

  always @(posedge clk) begin : status_check
    result_t got;
    result_t exp;
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        got = '{page_now: status_ch.page_now, stage_now: status_ch.stage_now,
                pump_line_selected: status_ch.pump_line_selected,
                pump_value_out: status_ch.pump_value_out, power_value: status_ch.power_value,
                loops: status_ch.loops, pulse_on: status_ch.pulse_on, dc_on: status_ch.dc_on,
                pulse_ready: status_ch.pulse_ready};
        n_results++;
        if (status_q.size() == 0) begin
          flag_error({"status beat with nothing expected: ", fmt_status(got)});
        end else begin
          exp = status_q.pop_front();
          if (got !== exp)
            flag_error($sformatf("status beat %0d mismatch\n  exp %s\n  got %s",
                                 n_results, fmt_status(exp), fmt_status(got)));
        end
      end
      status_ch.ready <= next_ready();
    end
  end

  function automatic tick_t make_tick(input bit a, input bit b, input bit btn, input bit a_rose,
                                      input bit b_rose, input bit p_done, input bit s_done);
    tick_t t;
    t.knob_a       = a;
    t.knob_b       = b;
    t.button_level = btn;
    t.a_rose       = a_rose;
    t.button_rose  = b_rose;
    t.pulse_done   = p_done;
    t.stage_done   = s_done;
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    result_t exp;
    tick_ch.valid        <= 1'b1;
    tick_ch.knob_a       <= t.knob_a;
    tick_ch.knob_b       <= t.knob_b;
    tick_ch.button_level <= t.button_level;
    tick_ch.a_rose       <= t.a_rose;
    tick_ch.button_rose  <= t.button_rose;
    tick_ch.pulse_done   <= t.pulse_done;
    tick_ch.stage_done   <= t.stage_done;
    do @(posedge clk); while (!tick_ch.ready);
    advance_menu(t, exp);
    status_q.push_back(exp);
    n_ticks++;
    burst_left--;
    if (burst_left <= 0) begin
      if (gap_max > 0) begin
        tick_ch.valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      end
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
    end
  endtask

  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_PULSE_PERIOD: menu_cfg.pulse_period = data;
      REG_HOLD_TICKS:   menu_cfg.hold_ticks   = data[10:0];
      REG_PUMP_LIMIT:   menu_cfg.pump_limit   = data[9:0];
      REG_LOOP_LIMIT:   menu_cfg.loop_limit   = data[7:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  task automatic quiet_ticks(input int n, input bit a);
    repeat (n) send_tick(make_tick(a, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic knob_turn(input bit fwd, input int extra);
    send_tick(make_tick(1'b1, !fwd, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (extra) send_tick(make_tick(1'b1, !fwd, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic turns(input bit fwd, input int n);
    repeat (n) knob_turn(fwd, 0);
  endtask

  task automatic hold_button(input int held);
    for (int i = 0; i < held; i++)
      send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b0, i == 0, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic ack(input bit p_done, input bit s_done);
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, p_done, s_done));
  endtask

  task automatic long_press();
    hold_button(menu_cfg.hold_ticks + 1);
  endtask

  task automatic test_reset_state();
    quiet_ticks(2, 1'b1);
  endtask

  task automatic test_register_writes();
    settle();
    write_reg(REG_HOLD_TICKS, 16'd1);
    write_reg(REG_PULSE_PERIOD, 16'd3);
    write_reg(REG_PUMP_LIMIT, 16'd4);
    write_reg(REG_LOOP_LIMIT, 16'd3);
    write_reg(REG_UNUSED, 16'hFFFF);
    quiet_ticks(3, 1'b1);
    ack(1'b1, 1'b0);
    quiet_ticks(2, 1'b1);
  endtask

  task automatic test_page_turns();
    turns(1'b1, 5);
    turns(1'b0, 1);
    turns(1'b1, 1);
    quiet_ticks(1, 1'b0);
    knob_turn(1'b1, 7);
    turns(1'b0, 1);
  endtask

  task automatic test_menu_edit();
    long_press();
    turns(1'b1, 1);
    turns(1'b0, 1);
    turns(1'b1, 1);
    long_press();
    turns(1'b0, 2);
    turns(1'b1, 3);
    ack(1'b0, 1'b1);
    long_press();
    turns(1'b1, 1);
    long_press();
    turns(1'b1, 6);
    turns(1'b0, 1);
    long_press();
    turns(1'b1, 4);
    turns(1'b0, 5);
    long_press();
    ack(1'b0, 1'b1);
    turns(1'b1, 2);
    long_press();
    ack(1'b0, 1'b1);
    turns(1'b0, 1);
    long_press();
    turns(1'b1, 3);
  endtask

  task automatic test_mode_toggles();
    long_press();
    long_press();
    turns(1'b1, 1);
    ack(1'b0, 1'b1);
    long_press();
    long_press();
    hold_button(1);
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(REG_PULSE_PERIOD, 16'd0);
    write_reg(REG_LOOP_LIMIT, 16'd0);
    write_reg(REG_PUMP_LIMIT, 16'd0);
    quiet_ticks(2, 1'b1);
    ack(1'b1, 1'b0);
    settle();
    write_reg(REG_PULSE_PERIOD, 16'hFFFF);
    write_reg(REG_PUMP_LIMIT, 16'd1023);
    write_reg(REG_LOOP_LIMIT, 16'd255);
    write_reg(REG_HOLD_TICKS, 16'd0);
    ack(1'b0, 1'b1);
    hold_button(1);
    quiet_ticks(2, 1'b1);
  endtask

  task automatic test_setting_ranges();
    settle();
    write_reg(REG_HOLD_TICKS, 16'd1);
    ack(1'b0, 1'b1);
    while (page != PAGE_FIRST) knob_turn(1'b1, 0);
    long_press();
    if (pump_sel) turns(1'b1, 1);
    long_press();
    turns(1'b0, 130);
    turns(1'b1, 260);
    ack(1'b0, 1'b1);
    long_press();
    turns(1'b1, 1);
    long_press();
    turns(1'b1, 1030);
    long_press();
    turns(1'b1, 260);
  endtask

  task automatic test_hold_saturation();
    settle();
    write_reg(REG_HOLD_TICKS, HOLD_MAX);
    ack(1'b0, 1'b1);
    hold_button(2100);
    settle();
    write_reg(REG_HOLD_TICKS, HOLD_MAX - 11'd1);
    hold_button(2050);
  endtask

  task automatic pick_registers();
    logic [15:0] v;
    case ($urandom_range(5, 0))
      0:       v = 16'd0;
      1:       v = 16'd1;
      2:       v = 16'hFFFF;
      default: v = $urandom_range(40, 2);
    endcase
    write_reg(REG_PULSE_PERIOD, v);
    case ($urandom_range(7, 0))
      0:       v = 16'd0;
      1:       v = HOLD_MAX;
      default: v = $urandom_range(6, 1);
    endcase
    write_reg(REG_HOLD_TICKS, {5'($urandom), v[10:0]});
    case ($urandom_range(5, 0))
      0:       v = 16'd0;
      1:       v = 16'd1023;
      default: v = $urandom_range(12, 1);
    endcase
    write_reg(REG_PUMP_LIMIT, {6'($urandom), v[9:0]});
    case ($urandom_range(5, 0))
      0:       v = 16'd0;
      1:       v = 16'd255;
      default: v = $urandom_range(8, 1);
    endcase
    write_reg(REG_LOOP_LIMIT, {8'($urandom), v[7:0]});
  endtask

  task automatic random_gesture();
    int held;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        if ($urandom_range(3, 0) == 0) quiet_ticks($urandom_range(3, 1), 1'b0);
        knob_turn($urandom_range(1, 0), $urandom_range(8, 0));
      end
      4, 5, 6: begin
        if (menu_cfg.hold_ticks > 20) held = $urandom_range(30, 1);
        else if ($urandom_range(3, 0) == 0) held = $urandom_range(menu_cfg.hold_ticks + 1, 1);
        else held = menu_cfg.hold_ticks + 1 + $urandom_range(2, 0);
        hold_button(held);
      end
      7: begin
        ack($urandom_range(1, 0), $urandom_range(3, 0) == 0);
      end
      default: begin
        repeat ($urandom_range(4, 1)) send_tick(tick_t'(7'($urandom)));
      end
    endcase
  endtask

  task automatic test_random_traffic();
    int start;
    start = n_ticks;
    while (n_ticks - start < RANDOM_TICKS) begin
      settle();
      pick_registers();
      gap_max = $urandom_range(6, 0);
      repeat ($urandom_range(40, 15)) random_gesture();
    end
  endtask

  initial begin
    tick_ch.valid        = 1'b0;
    tick_ch.knob_a       = 1'b0;
    tick_ch.knob_b       = 1'b0;
    tick_ch.button_level = 1'b0;
    tick_ch.a_rose       = 1'b0;
    tick_ch.button_rose  = 1'b0;
    tick_ch.pulse_done   = 1'b0;
    tick_ch.stage_done   = 1'b0;
    status_ch.ready      = 1'b0;
    reset_menu_model();
    burst_left = 1;
    gap_max    = 3;
    rx_left    = 0;
    rx_phase   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_register_writes();
    test_page_turns();
    test_menu_edit();
    test_mode_toggles();
    test_register_extremes();
    test_setting_ranges();
    test_hold_saturation();
    test_random_traffic();
    settle();
    if (status_q.size() != 0) flag_error("status beats still outstanding at end of run");
    $display("covered %0d ticks over %0d register writes; %0d knob turns, %0d long presses",
             n_ticks, n_writes, n_turns, n_presses);
    $display("checked %0d status beats, %0d mismatches", n_results, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d status beats outstanding", status_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
